@@ rtl/ccr_pkg.sv @@
// shared constants and helper function of the can controller register block
// no dependencies
`default_nettype none
package ccr_pkg;
  localparam int unsigned RxRingBytes = 64;
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FRAME = 2'd2;
  localparam logic [7:0] ST_P_RESET = 8'h3c;
  localparam logic [7:0] ST_B_RESET = 8'h0c;
  localparam logic [7:0] MODE_MASK  = 8'h1f;
  localparam logic [7:0] SFF_LOW    = 8'he0;
  localparam logic [7:0] EFF_LOW    = 8'hf8;
  localparam logic [7:0] DLC_MASK   = 8'h0f;
  localparam logic [7:0] PELI_SEL   = 8'h80;
  // input item: 2+5+8+29+1+1+1+4+64 = 115 bits, padded to 120
  localparam int unsigned InW  = 120;
  // result item: 8+1+1+29+1+1+4+64 = 109 bits, padded to 112
  localparam int unsigned OutW = 112;

  function automatic logic [3:0] data_len(input logic [3:0] dlc, input logic rtr);
    logic [3:0] r;
    r = (dlc > 4'd8) ? 4'd8 : dlc;
    return rtr ? 4'd0 : r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/can_controller_registers_top.sv @@
// can controller register block: register map, rx ring, tx frame builder
// depends on ccr_pkg
//
// channel  dir  fields (tdata, low bit first)
// s_axis   in   cmd, reg_addr, wr_data, rx_ident, rx_extended, rx_remote,
//               rx_error, rx_length, rx_payload
// m_axis   out  rd_data, irq_level, tx_valid, tx_ident, tx_extended,
//               tx_remote, tx_length, tx_payload
//
// a read, write or dropped frame passes the states RD1, RD2 and EXEC from
// accept to result; a stored frame then writes one ring byte per cycle (up to
// 13) through the single ring write port in the fill state before its result
// a release walks the ring header with one read of the ring port
// reset clears all control state; the ring contents are not cleared
// the block takes no item until the previous result has been taken
`default_nettype none
module can_controller_registers_top
  import ccr_pkg::*;
#(
  parameter int unsigned RX_RING_BYTES = RxRingBytes
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              s_axis_tvalid,
  output logic             s_axis_tready,
  // cmd, reg_addr, wr_data, rx_ident, rx_extended, rx_remote, rx_error,
  // rx_length, rx_payload, zero pad
  input  wire  [InW-1:0]   s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire              m_axis_tready,
  // rd_data, irq_level, tx_valid, tx_ident, tx_extended, tx_remote,
  // tx_length, tx_payload, zero pad
  output logic [OutW-1:0]  m_axis_tdata
);
  localparam int unsigned PW = $clog2(RX_RING_BYTES);
  localparam int unsigned CW = $clog2(RX_RING_BYTES + 1);

  typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_EXEC, S_FILL, S_OUT} state_e;
  state_e state_q;

  // latched input item
  logic [1:0]  cmd_q;
  logic [4:0]  addr_q;
  logic [7:0]  wd_q;
  logic [28:0] id_q;
  logic        ext_q, rtr_q, err_q;
  logic [3:0]  dlc_q;
  logic [63:0] pay_q;

  logic [4:0] mode_q, ctrl_q;
  logic [7:0] cdiv_q, stp_q, flp_q, ien_q, stb_q, flb_q, bcode_q, bmask_q;
  logic [7:0] acm_q [8];
  logic [7:0] txb_q [13];
  logic [7:0] ring_q [RX_RING_BYTES];
  logic [PW-1:0] rptr_q, wptr_q;
  logic [CW-1:0] bcnt_q;
  logic [CW-1:0] mcnt_q;

  // ring port read data and frame bytes to store
  logic [PW-1:0] raddr_q;
  logic [7:0]    rdat_q;
  logic [7:0]    fr_q [13];
  logic [3:0]    nfr_q, fi_q;

  logic [7:0]  rd_q;
  logic        txv_q, txe_q, txr_q;
  logic [28:0] txid_q;
  logic [3:0]  txl_q;
  logic [63:0] txp_q;

  logic peli;
  assign peli = cdiv_q[7];

  // unpack the incoming transaction
  logic [1:0]  in_cmd;
  logic [4:0]  in_addr;
  logic [28:0] in_id;
  assign in_cmd  = s_axis_tdata[1:0];
  assign in_addr = s_axis_tdata[6:2];
  assign in_id   = s_axis_tdata[43:15];

  // acceptance filter
  logic acc_ok;
  always_comb begin
    logic m0, m1, hit;
    logic [7:0] idh, idl, c, m;
    m0 = (pay_q[7:0] & ~acm_q[6]) == (acm_q[2] & ~acm_q[6]);
    m1 = (pay_q[15:8] & ~acm_q[7]) == (acm_q[3] & ~acm_q[7]);
    idh = id_q[10:3];
    idl = {id_q[2:0], 5'd0};
    c = {acm_q[1][3:0], acm_q[2][3:0]};
    m = ~{acm_q[5][3:0], acm_q[6][3:0]};
    hit = ((acm_q[0] & ~acm_q[4]) == (idh & ~acm_q[4])) &&
          (((acm_q[1] & ~acm_q[5]) & SFF_LOW) == ((idl & ~acm_q[5]) & SFF_LOW));
    if (ext_q) acc_ok = 1'b1;
    else if (mode_q[3]) begin
      if (rtr_q || dlc_q == 4'd0) acc_ok = 1'b1;
      else if (dlc_q == 4'd1) acc_ok = m0;
      else acc_ok = m0 && m1;
    end else if (hit && dlc_q != 4'd0) acc_ok = (c & m) == (pay_q[7:0] & m);
    else acc_ok = 1'b1;
  end

  // frame byte assembly
  logic [7:0] fr_c [13];
  logic [3:0] nfr_c, nd_c;
  always_comb begin
    logic [3:0] nh;
    nd_c = data_len(dlc_q, rtr_q);
    for (int k = 0; k < 13; k++) fr_c[k] = 8'd0;
    if (peli) begin
      fr_c[0] = {ext_q, rtr_q, 2'b00, dlc_q};
      if (ext_q) begin
        fr_c[1] = id_q[28:21];
        fr_c[2] = id_q[20:13];
        fr_c[3] = id_q[12:5];
        fr_c[4] = {id_q[4:0], 3'd0} & EFF_LOW;
        nh = 4'd5;
      end else begin
        fr_c[1] = id_q[10:3];
        fr_c[2] = {id_q[2:0], 5'd0};
        nh = 4'd3;
      end
    end else begin
      fr_c[0] = id_q[10:3];
      fr_c[1] = {id_q[2:0], rtr_q, dlc_q};
      nh = 4'd2;
    end
    for (int k = 0; k < 8; k++)
      if (4'(k) < nd_c) fr_c[nh + 4'(k)] = pay_q[8*k +: 8];
    nfr_c = nh + nd_c;
  end

  // transmit frame
  logic [28:0] tid_c;
  logic        text_c, trtr_c;
  logic [3:0]  tdlc_c;
  logic [63:0] tpay_c;
  always_comb begin
    logic [3:0] base, nd;
    if (peli) begin
      trtr_c = txb_q[0][6];
      text_c = txb_q[0][7];
      tdlc_c = txb_q[0][3:0];
      if (text_c) begin
        tid_c = {txb_q[1], txb_q[2], txb_q[3], txb_q[4][7:3]};
        base = 4'd5;
      end else begin
        tid_c = {18'd0, txb_q[1], txb_q[2][7:5]};
        base = 4'd3;
      end
    end else begin
      tid_c = {18'd0, txb_q[0], txb_q[1][7:5]};
      trtr_c = txb_q[1][4];
      text_c = 1'b0;
      tdlc_c = txb_q[1][3:0];
      base = 4'd2;
    end
    nd = data_len(tdlc_c, 1'b0);
    tpay_c = 64'd0;
    for (int k = 0; k < 8; k++)
      if (4'(k) < nd) tpay_c[8*k +: 8] = txb_q[base + 4'(k)];
  end

  // release length from the header byte read out of the ring
  logic [3:0] rel_c;
  assign rel_c = peli ? ((rdat_q[7] ? 4'd5 : 4'd3) + data_len(rdat_q[3:0], rdat_q[6]))
                      : (4'd2 + data_len(rdat_q[3:0], rdat_q[4]));

  // ring memory
  logic          rwe;
  logic [PW-1:0] rwa;
  logic [7:0]    rwd;
  assign rwe = (state_q == S_FILL);
  assign rwa = wptr_q;
  assign rwd = fr_q[fi_q];
  always_ff @(posedge clk_i) begin
    if (rwe) ring_q[rwa] <= rwd;
    rdat_q <= ring_q[raddr_q];
  end

  // ring read address for the latched access
  logic [PW-1:0] roff;
  always_comb begin
    roff = '0;
    if (cmd_q == CMD_READ)
      roff = peli ? PW'(addr_q - 5'd16) : PW'(addr_q - 5'd20);
    else if (!peli) roff = PW'(1);
  end

  // pointer sums, wrapped at the ring size where they are used
  logic [CW-1:0] rasum_c, rsum_c;
  assign rasum_c = CW'(rptr_q) + CW'(roff);
  assign rsum_c  = CW'(rptr_q) + CW'(rel_c);

  logic irq_c;
  assign irq_c = peli ? |(flp_q & ien_q) : |(flb_q & {4'd0, ctrl_q[4:1]});

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {3'd0, txp_q, txl_q, txr_q, txe_q, txid_q, txv_q, irq_c, rd_q};

  // sequencer and register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= 5'h01; ctrl_q <= 5'h01; cdiv_q <= '0;
      stp_q <= ST_P_RESET; stb_q <= ST_B_RESET;
      flp_q <= '0; flb_q <= '0; ien_q <= '0; bcode_q <= '0; bmask_q <= '0;
      for (int k = 0; k < 8; k++) acm_q[k] <= '0;
      for (int k = 0; k < 13; k++) txb_q[k] <= '0;
      rptr_q <= '0; wptr_q <= '0; bcnt_q <= '0; mcnt_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q <= in_cmd; addr_q <= in_addr; wd_q <= s_axis_tdata[14:7];
            id_q <= in_id; ext_q <= s_axis_tdata[44]; rtr_q <= s_axis_tdata[45];
            err_q <= s_axis_tdata[46]; dlc_q <= s_axis_tdata[50:47];
            pay_q <= s_axis_tdata[114:51];
            state_q <= S_RD1;
          end
        end
        S_RD1: begin
          raddr_q <= (rasum_c >= CW'(RX_RING_BYTES)) ? PW'(rasum_c - CW'(RX_RING_BYTES))
                                                     : PW'(rasum_c);
          state_q <= S_RD2;
        end
        S_RD2: state_q <= S_EXEC;
        S_EXEC: begin
          rd_q <= 8'd0; txv_q <= 1'b0; txid_q <= '0; txe_q <= 1'b0;
          txr_q <= 1'b0; txl_q <= '0; txp_q <= '0;
          state_q <= S_OUT;
          priority case (cmd_q)
            CMD_READ: begin
              if (peli) begin
                priority if (addr_q == 5'd0) rd_q <= {3'd0, mode_q};
                else if (addr_q == 5'd1) rd_q <= 8'd0;
                else if (addr_q == 5'd2) rd_q <= stp_q;
                else if (addr_q == 5'd3) begin
                  rd_q <= flp_q; flp_q <= {7'd0, mcnt_q != '0};
                end else if (addr_q == 5'd4) rd_q <= ien_q;
                else if (addr_q <= 5'd15) rd_q <= 8'd0;
                else if (addr_q <= 5'd28) begin
                  if (mode_q[0]) rd_q <= (addr_q < 5'd24) ? acm_q[addr_q[2:0]] : 8'd0;
                  else rd_q <= rdat_q;
                end else if (addr_q == 5'd31) rd_q <= cdiv_q;
                else rd_q <= 8'hff;
              end else begin
                priority if (addr_q == 5'd0) rd_q <= {3'd0, ctrl_q};
                else if (addr_q == 5'd2) rd_q <= stb_q;
                else if (addr_q == 5'd3) begin
                  rd_q <= flb_q; flb_q <= {7'd0, mcnt_q != '0};
                end else if (addr_q == 5'd4) rd_q <= bcode_q;
                else if (addr_q == 5'd5) rd_q <= bmask_q;
                else if (addr_q >= 5'd20 && addr_q <= 5'd29) rd_q <= rdat_q;
                else if (addr_q == 5'd31) rd_q <= cdiv_q;
                else rd_q <= 8'hff;
              end
            end
            CMD_WRITE: begin
              if (addr_q == 5'd1) begin
                // command register: transmit, release, clear overrun
                priority if (wd_q[0]) begin
                  txv_q <= 1'b1; txid_q <= tid_c; txe_q <= text_c; txr_q <= trtr_c;
                  txl_q <= tdlc_c; txp_q <= tpay_c;
                  if (peli) begin stp_q <= (stp_q | 8'h0c) & ~8'h20; flp_q <= flp_q | 8'h02; end
                  else begin stb_q <= (stb_q | 8'h0c) & ~8'h20; flb_q <= flb_q | 8'h02; end
                end else if (wd_q[2]) begin
                  if (mcnt_q != '0) begin
                    rptr_q <= (rsum_c >= CW'(RX_RING_BYTES))
                              ? PW'(rsum_c - CW'(RX_RING_BYTES)) : PW'(rsum_c);
                    bcnt_q <= (bcnt_q > CW'(rel_c)) ? bcnt_q - CW'(rel_c) : '0;
                    mcnt_q <= mcnt_q - CW'(1);
                    if (mcnt_q == CW'(1)) begin
                      if (peli) begin stp_q[0] <= 1'b0; flp_q[0] <= 1'b0; end
                      else begin stb_q[0] <= 1'b0; flb_q[0] <= 1'b0; end
                    end
                  end
                end else if (wd_q[3]) begin
                  if (peli) begin stp_q[1] <= 1'b0; flp_q[3] <= 1'b0; end
                  else begin stb_q[1] <= 1'b0; flb_q[3] <= 1'b0; end
                end
              end else if (addr_q == 5'd31) cdiv_q <= wd_q;
              else if (peli) begin
                if (addr_q == 5'd0) begin
                  if (mode_q[0] && !wd_q[0]) begin
                    rptr_q <= '0; wptr_q <= '0; bcnt_q <= '0; mcnt_q <= '0;
                  end
                  mode_q <= wd_q[4:0];
                end else if (addr_q == 5'd4) ien_q <= wd_q;
                else if (addr_q >= 5'd16 && addr_q <= 5'd28) begin
                  if (addr_q == 5'd16) stp_q[5] <= 1'b1;
                  if (mode_q[0]) begin
                    if (addr_q < 5'd24) acm_q[addr_q[2:0]] <= wd_q;
                  end else txb_q[4'(addr_q - 5'd16)] <= wd_q;
                end
              end else begin
                if (addr_q == 5'd0) begin
                  if (!wd_q[0]) begin
                    rptr_q <= '0; wptr_q <= '0; bcnt_q <= '0; mcnt_q <= '0;
                    if (!ctrl_q[0]) begin
                      mode_q <= (mode_q & ~5'h11) | 5'h01;
                      stp_q <= (stp_q & ~8'h37) | 8'h34;
                    end
                  end
                  ctrl_q <= wd_q[4:0];
                end else if (addr_q == 5'd4) bcode_q <= wd_q;
                else if (addr_q == 5'd5) bmask_q <= wd_q;
                else if (addr_q >= 5'd10 && addr_q <= 5'd19) begin
                  if (addr_q == 5'd10) stb_q[5] <= 1'b1;
                  if (!ctrl_q[0]) txb_q[4'(addr_q - 5'd10)] <= wd_q;
                end
              end
            end
            CMD_FRAME: begin
              if (!err_q && (peli ? (!mode_q[0] && acc_ok) : (!ctrl_q[0] && !ext_q))) begin
                if (CW'(bcnt_q) + CW'(nfr_c) > CW'(RX_RING_BYTES)
                    || bcnt_q + CW'(nfr_c) < bcnt_q) begin
                  if (peli) begin stp_q[1] <= 1'b1; flp_q[3] <= 1'b1; end
                  else begin stb_q[1] <= 1'b1; flb_q[3] <= 1'b1; end
                end else begin
                  fr_q <= fr_c; nfr_q <= nfr_c; fi_q <= '0;
                  bcnt_q <= bcnt_q + CW'(nfr_c);
                  mcnt_q <= mcnt_q + CW'(1);
                  if (peli) begin stp_q[0] <= 1'b1; flp_q[0] <= 1'b1; end
                  else begin stb_q[0] <= 1'b1; flb_q[0] <= 1'b1; end
                  state_q <= S_FILL;
                end
              end
            end
            default: ;
          endcase
        end
        S_FILL: begin
          wptr_q <= (wptr_q == PW'(RX_RING_BYTES - 1)) ? '0 : wptr_q + PW'(1);
          fi_q <= fi_q + 4'd1;
          if (fi_q + 4'd1 == nfr_q) state_q <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // no input taken while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  // a held result keeps its read data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata[7:0]))
    else $error("result changed under stall");
  // byte count never exceeds the ring
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= CW'(RX_RING_BYTES)) else $error("ring byte count overflow");
endmodule
`default_nettype wire

@@ tb/tb_can_controller_registers_top.sv @@
// self-checking testbench for can_controller_registers_top: register accesses,
// received frames and transmit requests on the stream ports, checked against
// a cycle-free model of the register map and rx ring; depends on ccr_pkg
`timescale 1ns / 100ps
module tb_can_controller_registers_top;
  import ccr_pkg::*;

  localparam int unsigned NumRandom = 650;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 400;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  // command register bits and register addresses
  localparam logic [7:0] CMD_TX = 8'h01;
  localparam logic [7:0] CMD_REL = 8'h04;
  localparam logic [7:0] CMD_CLR_OVR = 8'h08;
  localparam logic [4:0] A_MODE = 5'd0;
  localparam logic [4:0] A_CMD = 5'd1;
  localparam logic [4:0] A_STATUS = 5'd2;
  localparam logic [4:0] A_IRQ = 5'd3;
  localparam logic [4:0] A_IEN = 5'd4;
  localparam logic [4:0] A_BMASK = 5'd5;
  localparam logic [4:0] A_BTX = 5'd10;
  localparam logic [4:0] A_PBUF = 5'd16;
  localparam logic [4:0] A_BRX = 5'd20;
  localparam logic [4:0] A_CDIV = 5'd31;

  typedef struct {
    logic [1:0]  cmd;
    logic [4:0]  addr;
    logic [7:0]  wdata;
    logic [28:0] id;
    logic        ext;
    logic        rtr;
    logic        err;
    logic [3:0]  len;
    logic [63:0] pay;
  } access_t;

  typedef struct {
    logic [7:0]  rd;
    logic        irq;
    logic        txv;
    logic [28:0] tid;
    logic        text;
    logic        trtr;
    logic [3:0]  tlen;
    logic [63:0] tpay;
  } reply_t;

  typedef struct {
    access_t    it;
    bit         typed;
    logic [7:0] rd;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OutW-1:0] m_axis_tdata;

  can_controller_registers_top uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // shadow copy of the register map and rx ring
  logic [7:0] mode_q, cdiv_q, stat_p, flg_p, ien_q, ctrl_b, stat_b, flg_b;
  logic [7:0] acm[8];
  logic [7:0] bcode, bmask;
  logic [7:0] txb[13];
  logic [7:0] ring[64];
  bit         ring_valid[64];
  logic [5:0] rd_ptr, wr_ptr;
  int         byte_cnt, msg_cnt;

  reply_t replies_due[$];
  int     fail_cnt = 0;
  int     cycles = 0;
  int     calm_left = 0;
  bit     hold_req = 0;
  bit     hold_done = 0;

  function automatic void shadow_reset();
    mode_q = 8'h01; cdiv_q = 0; stat_p = ST_P_RESET; flg_p = 0; ien_q = 0;
    ctrl_b = 8'h01; stat_b = ST_B_RESET; flg_b = 0; bcode = 0; bmask = 0;
    foreach (acm[i]) acm[i] = 0;
    foreach (txb[i]) txb[i] = 0;
    foreach (ring_valid[i]) ring_valid[i] = 0;
    rd_ptr = 0; wr_ptr = 0; byte_cnt = 0; msg_cnt = 0;
  endfunction

  function automatic void ring_clear();
    rd_ptr = 0; wr_ptr = 0; byte_cnt = 0; msg_cnt = 0;
  endfunction

  function automatic logic [7:0] ring_byte(int off);
    logic [5:0] p;
    p = rd_ptr + off[5:0];
    return ring[p];
  endfunction

  function automatic bit ring_byte_ok(int off);
    logic [5:0] p;
    p = rd_ptr + off[5:0];
    return ring_valid[p];
  endfunction

  function automatic int payload_bytes(logic [3:0] dlc, logic rtr);
    if (rtr) return 0;
    return (dlc > 8) ? 8 : int'(dlc);
  endfunction

  // acceptance filter of the extended map, single filter on std frames
  function automatic bit filter_pass(access_t it);
    logic [7:0] d0, d1, idh, idl, c, m;
    bit m0, m1;
    d0 = it.pay[7:0];
    d1 = it.pay[15:8];
    if (it.ext) return 1;
    if (mode_q[3]) begin
      m0 = (d0 & ~acm[6]) == (acm[2] & ~acm[6]);
      m1 = (d1 & ~acm[7]) == (acm[3] & ~acm[7]);
      if (it.rtr || it.len == 0) return 1;
      if (it.len == 1) return m0;
      return m0 && m1;
    end
    idh = it.id[10:3];
    idl = {it.id[2:0], 5'b0};
    if ((acm[0] & ~acm[4]) == (idh & ~acm[4]) &&
        ((acm[1] & ~acm[5]) & SFF_LOW) == ((idl & ~acm[5]) & SFF_LOW)) begin
      if (it.len == 0) return 1;
      c = {acm[1][3:0], acm[2][3:0]};
      m = ~{acm[5][3:0], acm[6][3:0]};
      return (c & m) == (d0 & m);
    end
    return 1;
  endfunction

  function automatic void frame_in(access_t it);
    bit peli;
    logic [7:0] fr[13];
    int n, nd;
    peli = cdiv_q[7];
    n = 0;
    nd = payload_bytes(it.len, it.rtr);
    if (peli) begin
      if (mode_q[0] || !filter_pass(it) || it.err) return;
      fr[n++] = {it.ext, it.rtr, 2'b0, it.len};
      if (it.ext) begin
        fr[n++] = it.id[28:21];
        fr[n++] = it.id[20:13];
        fr[n++] = it.id[12:5];
        fr[n++] = {it.id[4:0], 3'b0};
      end else begin
        fr[n++] = it.id[10:3];
        fr[n++] = {it.id[2:0], 5'b0};
      end
    end else begin
      if (ctrl_b[0] || it.ext || it.err) return;
      fr[n++] = it.id[10:3];
      fr[n++] = {it.id[2:0], it.rtr, it.len};
    end
    for (int i = 0; i < nd; i++) fr[n++] = it.pay[8*i +: 8];
    if (byte_cnt + n > 64) begin
      if (peli) begin
        stat_p |= 8'h02; flg_p |= 8'h08;
      end else begin
        stat_b |= 8'h02; flg_b |= 8'h08;
      end
      return;
    end
    for (int i = 0; i < n; i++) begin
      ring[wr_ptr] = fr[i];
      ring_valid[wr_ptr] = 1;
      wr_ptr++;
    end
    byte_cnt += n;
    msg_cnt++;
    if (peli) begin
      stat_p |= 8'h01; flg_p |= 8'h01;
    end else begin
      stat_b |= 8'h01; flg_b |= 8'h01;
    end
  endfunction

  // transmit wins over release, release over clear overrun
  function automatic void command_wr(logic [7:0] v, bit peli, ref reply_t r);
    logic [7:0] st, fl, b0;
    int base, nd, cnt;
    st = peli ? stat_p : stat_b;
    fl = peli ? flg_p : flg_b;
    if (v & CMD_TX) begin
      r.txv = 1;
      r.tpay = 0;
      if (peli) begin
        b0 = txb[0];
        r.trtr = b0[6];
        r.text = b0[7];
        r.tlen = b0[3:0];
        if (b0[7]) begin
          r.tid = {txb[1], txb[2], txb[3], txb[4][7:3]};
          base = 5;
        end else begin
          r.tid = {18'b0, txb[1], txb[2][7:5]};
          base = 3;
        end
      end else begin
        r.tid = {18'b0, txb[0], txb[1][7:5]};
        r.trtr = txb[1][4];
        r.text = 0;
        r.tlen = txb[1][3:0];
        base = 2;
      end
      nd = (r.tlen > 8) ? 8 : int'(r.tlen);
      for (int i = 0; i < nd; i++) r.tpay[8*i +: 8] = txb[base + i];
      st = (st | 8'h0c) & ~8'h20;
      fl |= 8'h02;
    end else if (v & CMD_REL) begin
      if (msg_cnt == 0) return;
      if (peli) begin
        b0 = ring_byte(0);
        cnt = (b0[7] ? 5 : 3) + payload_bytes(b0[3:0], b0[6]);
      end else begin
        b0 = ring_byte(1);
        cnt = 2 + payload_bytes(b0[3:0], b0[4]);
      end
      rd_ptr = rd_ptr + cnt[5:0];
      byte_cnt = (byte_cnt > cnt) ? byte_cnt - cnt : 0;
      msg_cnt--;
      if (msg_cnt == 0) begin
        st &= ~8'h01; fl &= ~8'h01;
      end
    end else if (v & CMD_CLR_OVR) begin
      st &= ~8'h02; fl &= ~8'h08;
    end
    if (peli) begin
      stat_p = st; flg_p = fl;
    end else begin
      stat_b = st; flg_b = fl;
    end
  endfunction

  function automatic logic [7:0] reg_read(logic [4:0] a);
    logic [7:0] t;
    if (cdiv_q[7]) begin
      if (a == A_MODE) return mode_q;
      if (a == A_CMD) return 0;
      if (a == A_STATUS) return stat_p;
      if (a == A_IRQ) begin
        t = flg_p; flg_p = msg_cnt ? 8'h01 : 8'h00; return t;
      end
      if (a == A_IEN) return ien_q;
      if (a < A_PBUF) return 0;
      if (a <= 28) begin
        if (mode_q[0]) return (a < 24) ? acm[a - 16] : 8'h00;
        return ring_byte(a - 16);
      end
      if (a == A_CDIV) return cdiv_q;
      return 8'hff;
    end
    if (a == A_MODE) return ctrl_b;
    if (a == A_STATUS) return stat_b;
    if (a == A_IRQ) begin
      t = flg_b; flg_b = msg_cnt ? 8'h01 : 8'h00; return t;
    end
    if (a == A_IEN) return bcode;
    if (a == A_BMASK) return bmask;
    if (a >= A_BRX && a <= 29) return ring_byte(a - 20);
    if (a == A_CDIV) return cdiv_q;
    return 8'hff;
  endfunction

  function automatic void reg_write(logic [4:0] a, logic [7:0] v, ref reply_t r);
    if (cdiv_q[7]) begin
      if (a == A_MODE) begin
        if (mode_q[0] && !v[0]) ring_clear();
        mode_q = v & MODE_MASK;
      end else if (a == A_CMD) command_wr(v, 1, r);
      else if (a == A_IEN) ien_q = v;
      else if (a >= A_PBUF && a <= 28) begin
        if (a == A_PBUF) stat_p |= 8'h20;
        if (mode_q[0]) begin
          if (a < 24) acm[a - 16] = v;
        end else txb[a - 16] = v;
      end else if (a == A_CDIV) cdiv_q = v;
      return;
    end
    if (a == A_MODE) begin
      if (ctrl_b[0] && !v[0]) ring_clear();
      else if (!ctrl_b[0] && !v[0]) begin
        // software reset while operating
        mode_q = (mode_q & ~8'h31) | 8'h01;
        stat_p = (stat_p & ~8'h37) | 8'h34;
        ring_clear();
      end
      ctrl_b = v & MODE_MASK;
    end else if (a == A_CMD) command_wr(v, 0, r);
    else if (a == A_IEN) bcode = v;
    else if (a == A_BMASK) bmask = v;
    else if (a >= A_BTX && a <= 19) begin
      if (a == A_BTX) stat_b |= 8'h20;
      if (!ctrl_b[0]) txb[a - 10] = v;
    end else if (a == A_CDIV) cdiv_q = v;
  endfunction

  function automatic reply_t predict_access(access_t it);
    reply_t r;
    r = '{default: '0};
    case (it.cmd)
      CMD_READ:  r.rd = reg_read(it.addr);
      CMD_WRITE: reg_write(it.addr, it.wdata, r);
      CMD_FRAME: frame_in(it);
      default: ;
    endcase
    if (cdiv_q[7]) r.irq = (flg_p & ien_q) != 0;
    else r.irq = (flg_b & (ctrl_b >> 1) & 8'h0f) != 0;
    return r;
  endfunction

  // a read of a ring byte that was never written is turned into a status read
  function automatic access_t guard_ring_read(access_t it);
    int off;
    off = -1;
    if (it.cmd != CMD_READ) return it;
    if (cdiv_q[7] && !mode_q[0] && it.addr >= A_PBUF && it.addr <= 28) off = it.addr - 16;
    if (!cdiv_q[7] && it.addr >= A_BRX && it.addr <= 29) off = it.addr - 20;
    if (off >= 0 && !ring_byte_ok(off)) it.addr = A_STATUS;
    return it;
  endfunction

  function automatic access_t mk(logic [1:0] c, logic [4:0] a, logic [7:0] d);
    access_t it;
    it = '{default: '0};
    it.cmd = c; it.addr = a; it.wdata = d;
    return it;
  endfunction

  function automatic access_t mk_frame(logic [28:0] id, logic ext, logic rtr, logic err,
                                       logic [3:0] len, logic [63:0] pay);
    access_t it;
    it = mk(CMD_FRAME, 0, 0);
    it.id = id; it.ext = ext; it.rtr = rtr; it.err = err; it.len = len; it.pay = pay;
    return it;
  endfunction

  function automatic access_t random_access();
    access_t it;
    int r, s;
    it.addr = $urandom_range(0, 31);
    it.wdata = $urandom_range(0, 255);
    it.id = $urandom;
    it.ext = ($urandom_range(0, 9) < 3);
    it.rtr = ($urandom_range(0, 9) < 2);
    it.err = ($urandom_range(0, 9) == 0);
    it.len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    it.pay = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    if (r < 35) it.cmd = CMD_FRAME;
    else if (r < 50) begin
      it.cmd = CMD_READ;
      if (s < 40) it.addr = (s < 10) ? A_MODE : (s < 20) ? A_STATUS : (s < 30) ? A_IRQ : A_IEN;
      else if (s < 70) it.addr = cdiv_q[7] ? $urandom_range(16, 28) : $urandom_range(20, 29);
    end else if (r < 98) begin
      it.cmd = CMD_WRITE;
      if (s < 15) begin
        it.addr = A_MODE;
        it.wdata[0] = ($urandom_range(0, 3) == 0);
      end else if (s < 40) begin
        it.addr = A_CMD;
        case ($urandom_range(0, 4))
          0: it.wdata = CMD_TX;
          1, 2: it.wdata = CMD_REL;
          3: it.wdata = CMD_CLR_OVR;
          default: ;
        endcase
      end else if (s < 70) it.addr = cdiv_q[7] ? $urandom_range(16, 28) : $urandom_range(10, 19);
      else if (s < 80) it.addr = $urandom_range(A_IEN, A_BMASK);
      else if (s < 85) it.addr = A_CDIV;
    end else it.cmd = CMD_UNKNOWN;
    return guard_ring_read(it);
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm_left = 50;
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one transaction, hold it until the block takes it
  task automatic offer(access_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, it.pay, it.len, it.err, it.rtr, it.ext, it.id, it.wdata,
                     it.addr, it.cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      fail_cnt++;
    end
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (replies_due.size() == 0) begin
        $error("result transaction with no expectation pending");
        fail_cnt++;
      end else begin
        e = replies_due.pop_front();
        check_field("rd_data", e.rd, m_axis_tdata[7:0]);
        check_field("irq_level", e.irq, m_axis_tdata[8]);
        check_field("tx_valid", e.txv, m_axis_tdata[9]);
        check_field("tx_ident", e.tid, m_axis_tdata[38:10]);
        check_field("tx_extended", e.text, m_axis_tdata[39]);
        check_field("tx_remote", e.trtr, m_axis_tdata[40]);
        check_field("tx_length", e.tlen, m_axis_tdata[44:41]);
        check_field("tx_payload", e.tpay, m_axis_tdata[108:45]);
      end
    end
  end

  // stimulus
  initial begin
    row_t rows[$];
    access_t it;
    reply_t e;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    rst_ni = 1'b0;
    shadow_reset();

    // directed: reset values, basic map, then the extended map
    rows.push_back('{mk(CMD_READ, A_MODE, 0), 1, 8'h01});
    rows.push_back('{mk(CMD_READ, A_STATUS, 0), 1, ST_B_RESET});
    rows.push_back('{mk(CMD_READ, A_CMD, 0), 1, 8'hff});
    rows.push_back('{mk(CMD_UNKNOWN, A_MODE, 8'hff), 0, 0});
    rows.push_back('{mk_frame(29'h7ff, 0, 0, 0, 4'd8, '1), 0, 0});
    rows.push_back('{mk(CMD_WRITE, A_MODE, 8'h1e), 0, 0});
    rows.push_back('{mk(CMD_WRITE, A_BTX, 8'hff), 0, 0});
    rows.push_back('{mk(CMD_WRITE, A_BTX + 1, 8'hff), 0, 0});
    rows.push_back('{mk(CMD_WRITE, A_BTX + 2, 8'ha5), 0, 0});
    rows.push_back('{mk(CMD_WRITE, A_CMD, 8'h0d), 0, 0});
    rows.push_back('{mk_frame('1, 0, 0, 0, 4'd8, '1), 0, 0});
    rows.push_back('{mk_frame('1, 1, 0, 0, 4'd8, '1), 0, 0});
    rows.push_back('{mk_frame(29'h155, 0, 0, 1, 4'd3, 64'h1234), 0, 0});
    rows.push_back('{mk_frame(29'h2aa, 0, 1, 0, 4'd15, '1), 0, 0});
    rows.push_back('{mk(CMD_READ, A_BRX + 1, 0), 0, 0});
    rows.push_back('{mk(CMD_READ, A_IRQ, 0), 0, 0});
    rows.push_back('{mk(CMD_WRITE, A_CMD, CMD_REL), 0, 0});
    rows.push_back('{mk(CMD_WRITE, A_CMD, CMD_REL), 0, 0});
    rows.push_back('{mk(CMD_WRITE, A_CMD, CMD_REL), 0, 0});
    rows.push_back('{mk(CMD_WRITE, A_MODE, 8'h00), 0, 0});
    rows.push_back('{mk(CMD_WRITE, A_CDIV, PELI_SEL), 0, 0});
    rows.push_back('{mk(CMD_READ, A_STATUS, 0), 1, ST_P_RESET});
    rows.push_back('{mk(CMD_WRITE, A_PBUF + 4, 8'hff), 0, 0});
    rows.push_back('{mk(CMD_WRITE, A_IEN, 8'hff), 0, 0});
    rows.push_back('{mk(CMD_WRITE, A_MODE, 8'h08), 0, 0});
    rows.push_back('{mk_frame('1, 1, 0, 0, 4'd8, '1), 0, 0});
    rows.push_back('{mk(CMD_READ, A_PBUF + 12, 0), 0, 0});
    rows.push_back('{mk(CMD_WRITE, A_CDIV, 8'h00), 0, 0});

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      it = guard_ring_read(rows[i].it);
      e = predict_access(it);
      if (rows[i].typed) e.rd = rows[i].rd;
      replies_due.push_back(e);
      offer(it);
    end

    // random part
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 200) hold_req = 1;
      it = random_access();
      replies_due.push_back(predict_access(it));
      offer(it);
    end
    s_axis_tvalid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
